// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the echo suppressor core.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/fes_pkg.sv =====
// Package for the frame echo suppressor: widths, codes, reset values and the
// command and status structures between controller and datapath. No dependencies.
package fes_pkg;

    localparam int FRAME_LEN = 160;

    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 23;
    localparam int LVL_W    = 16;
    localparam int HOLD_W   = 16;
    localparam int AVG_W    = 16;
    localparam int CNT_W    = 8;
    localparam int TOT_W    = 32;
    localparam int TYPE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam int DIV_W  = CNT_W;
    localparam int STEP_W = $clog2(TOT_W);

    // The frame mean is the product of the sum and a rounded-up reciprocal of the
    // frame length, which is exact for every sum below 2^SUM_W.
    localparam int MEAN_SH = SUM_W + $clog2(FRAME_LEN);
    localparam int RCP_W   = SUM_W + 2;
    localparam int PROD_W  = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] MEAN_RCP =
        RCP_W'(((64'd1 << MEAN_SH) + 64'(FRAME_LEN - 1)) / 64'(FRAME_LEN));

    localparam logic [SUM_W-1:0]  SUM_MAX       = '1;
    localparam logic [HOLD_W-1:0] HOLD_MS_RST   = HOLD_W'(300);
    localparam logic [LVL_W-1:0]  SPK_LEVEL_RST = LVL_W'(300);
    localparam logic [LVL_W-1:0]  ACT_LEVEL_RST = LVL_W'(200);
    localparam logic [CNT_W-1:0]  AVG_PER_RST   = CNT_W'(250);
    localparam logic [AVG_W-1:0]  AVG_WITH_RST  = AVG_W'(200);

    typedef enum logic [TYPE_W-1:0] {
        REQ_SPK  = 2'd0,
        REQ_MIC  = 2'd1,
        REQ_TICK = 2'd2,
        REQ_NONE = 2'd3
    } t_req_type;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOLD_MS    = 2'd0,
        CFG_SPK_LEVEL  = 2'd1,
        CFG_ACT_LEVEL  = 2'd2,
        CFG_AVG_PERIOD = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic acc;
        logic mean_take;
        logic fold;
        logic avg_start;
        logic avg_take;
        logic emit;
    } t_fes_cmd;

    typedef struct packed {
        logic frame;
        logic is_spk;
        logic loud;
        logic div_done;
        logic out_free;
    } t_fes_status;

endpackage

// ===== rtl/core/fes_if.sv =====
// Handshake channel interfaces of the frame echo suppressor: requests, results
// and configuration writes. Depends on fes_pkg.
interface fes_req_if
    import fes_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [TYPE_W-1:0]          req_type;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;

    modport source (output valid, req_type, sample, frame_end, input ready);
    modport sink   (input valid, req_type, sample, frame_end, output ready);
endinterface

interface fes_res_if
    import fes_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             suppress;
    logic             speaker_active;
    logic [AVG_W-1:0] level_with_speaker;
    logic [AVG_W-1:0] level_without_speaker;

    modport source (output valid, suppress, speaker_active, level_with_speaker,
                    level_without_speaker, input ready);
    modport sink   (input valid, suppress, speaker_active, level_with_speaker,
                    level_without_speaker, output ready);
endinterface

interface fes_cfg_if
    import fes_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/fes_div.sv =====
// Restoring divider of the echo suppressor, one quotient bit per cycle.
// Depends on fes_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fes_div
    import fes_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [TOT_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [TOT_W-1:0] o_quot
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [TOT_W-1:0]  r_quot, n_quot;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W:0]    trial;
    logic              fits;

    always_comb begin
        trial  = {r_rem, r_quot[TOT_W-1]};
        fits   = trial >= {1'b0, r_div};
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[TOT_W-2:0], fits};
            n_rem  = fits ? DIV_W'(trial - {1'b0, r_div}) : trial[DIV_W-1:0];
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(TOT_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    `CHK_NOW(a_start_idle, i_start, !r_busy, "Division started while one is running.")
    `CHK_NOW(a_rem_below_div, r_done, r_rem < r_div, "Remainder not below divisor.")

endmodule

// ===== rtl/core/fes_ctrl.sv =====
// Controller state machine of the echo suppressor: sequences accumulation,
// the frame mean, the average division and the result. Depends on fes_pkg.
`include "assert_macros.svh"

module fes_ctrl
    import fes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_fes_status i_st,
    output logic        o_in_ready,
    output t_fes_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACC    = 7'b0000010,
        S_MEAN   = 7'b0000100,
        S_FOLD   = 7'b0001000,
        S_AVG_GO = 7'b0010000,
        S_AVG    = 7'b0100000,
        S_DECIDE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_st.frame ? S_MEAN : S_IDLE;
            end
            S_MEAN: begin
                o_cmd.mean_take = 1'b1;
                n_state         = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (i_st.is_spk) begin
                    n_state = S_IDLE;
                end else if (i_st.loud) begin
                    n_state = S_AVG_GO;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_AVG_GO: begin
                o_cmd.avg_start = 1'b1;
                n_state         = S_AVG;
            end
            S_AVG: begin
                if (i_st.div_done) begin
                    o_cmd.avg_take = 1'b1;
                    n_state        = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CHK_NEXT(a_accept_acc, o_cmd.accept, r_state == S_ACC, "Request not followed by accumulation.")
    `CHK_NEXT(a_emit_idle, o_cmd.emit, r_state == S_IDLE, "Controller not idle after a result.")

endmodule

// ===== rtl/core/fes_dp.sv =====
// Datapath of the echo suppressor: configuration, frame sums, hold countdown,
// running averages, decision and result register. Depends on fes_pkg and fes_div.
`include "assert_macros.svh"

module fes_dp
    import fes_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fes_cmd                   i_cmd,
    output t_fes_status                o_st,
    input  logic [TYPE_W-1:0]          i_req_type,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_frame_end,
    input  logic                       i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DAT_W-1:0]       i_cfg_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_suppress,
    output logic                       o_speaker_active,
    output logic [AVG_W-1:0]           o_level_with,
    output logic [AVG_W-1:0]           o_level_without
);

    logic [HOLD_W-1:0] r_hold_ms;
    logic [LVL_W-1:0]  r_spk_level;
    logic [LVL_W-1:0]  r_act_level;
    logic [CNT_W-1:0]  r_avg_period;

    t_req_type                  r_type;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic                       r_end;
    logic                       r_active;
    logic [SUM_W-1:0]           r_frame_sum;
    logic [SUM_W-1:0]           r_mean;

    logic [SUM_W-1:0]  r_mic_sum, r_spk_sum;
    logic [HOLD_W-1:0] r_hold;
    logic [TOT_W-1:0]  r_tot_w, r_tot_wo;
    logic [CNT_W-1:0]  r_cnt_w, r_cnt_wo;
    logic [AVG_W-1:0]  r_avg_w, r_avg_wo;

    logic             r_out_valid;
    logic             r_suppress, r_spk_active;
    logic [AVG_W-1:0] r_out_w, r_out_wo;

    logic [SAMPLE_W-1:0] mag;
    logic [SUM_W-1:0]    cur_sum;
    logic [SUM_W:0]      raw_sum;
    logic [SUM_W-1:0]    n_sum;
    logic                is_spk;
    logic                frame;
    logic [PROD_W-1:0]   mean_prod;
    logic [SUM_W-1:0]    mean_calc;

    logic [TOT_W-1:0] tot_sel;
    logic [CNT_W-1:0] cnt_sel;
    logic [CNT_W:0]   cnt_next;
    logic             restart;
    logic [AVG_W-1:0] new_avg;

    logic             div_start;
    logic [TOT_W-1:0] div_dividend;
    logic [DIV_W-1:0] div_divisor;
    logic             div_done;
    logic [TOT_W-1:0] div_quot;

    logic [SUM_W-1:0] diff;
    logic [AVG_W-1:0] t_lvl;
    logic [AVG_W+1:0] lhs, rhs;
    logic             pass;
    logic             n_suppress;

    always_comb begin
        is_spk  = r_type == REQ_SPK;
        frame   = r_end && (r_type == REQ_SPK || r_type == REQ_MIC);
        mag     = r_sample[SAMPLE_W-1] ? SAMPLE_W'(-r_sample) : SAMPLE_W'(r_sample);
        cur_sum = is_spk ? r_spk_sum : r_mic_sum;
        raw_sum = {1'b0, cur_sum} + (SUM_W + 1)'(mag);
        n_sum   = raw_sum[SUM_W] ? SUM_MAX : raw_sum[SUM_W-1:0];

        mean_prod = {{RCP_W{1'b0}}, r_frame_sum} * {{SUM_W{1'b0}}, MEAN_RCP};
        mean_calc = SUM_W'(mean_prod >> MEAN_SH);

        tot_sel  = r_active ? r_tot_w : r_tot_wo;
        cnt_sel  = r_active ? r_cnt_w : r_cnt_wo;
        cnt_next = {1'b0, cnt_sel} + (CNT_W + 1)'(1);
        restart  = (cnt_next > {1'b0, r_avg_period}) || cnt_next[CNT_W];
        new_avg  = div_quot[AVG_W-1:0];

        div_start    = i_cmd.avg_start;
        div_dividend = tot_sel;
        div_divisor  = (cnt_sel == '0) ? DIV_W'(1) : DIV_W'(cnt_sel);

        diff  = (r_mean > SUM_W'(r_avg_wo)) ? r_mean - SUM_W'(r_avg_wo) : '0;
        t_lvl = diff[AVG_W-1:0];
        lhs   = (AVG_W + 2)'({t_lvl, 1'b0});
        rhs   = (AVG_W + 2)'(r_avg_w) + (AVG_W + 2)'({r_avg_w, 1'b0});
        pass  = (lhs > rhs) && (t_lvl >= r_avg_wo) && (r_avg_wo != '0);
        n_suppress = r_active && !pass;

        o_st.frame    = frame;
        o_st.is_spk   = is_spk;
        o_st.loud     = r_mean > SUM_W'(r_act_level);
        o_st.div_done = div_done;
        o_st.out_free = !r_out_valid || i_out_ready;
    end

    fes_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ms    <= HOLD_MS_RST;
            r_spk_level  <= SPK_LEVEL_RST;
            r_act_level  <= ACT_LEVEL_RST;
            r_avg_period <= AVG_PER_RST;
            r_mic_sum    <= '0;
            r_spk_sum    <= '0;
            r_hold       <= '0;
            r_tot_w      <= '0;
            r_cnt_w      <= '0;
            r_avg_w      <= AVG_WITH_RST;
            r_tot_wo     <= '0;
            r_cnt_wo     <= '0;
            r_avg_wo     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HOLD_MS:    r_hold_ms    <= HOLD_W'(i_cfg_data);
                    CFG_SPK_LEVEL:  r_spk_level  <= LVL_W'(i_cfg_data);
                    CFG_ACT_LEVEL:  r_act_level  <= LVL_W'(i_cfg_data);
                    CFG_AVG_PERIOD: r_avg_period <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_cmd.acc) begin
                case (r_type)
                    REQ_SPK: r_spk_sum <= frame ? '0 : n_sum;
                    REQ_MIC: r_mic_sum <= frame ? '0 : n_sum;
                    REQ_TICK: begin
                        if (r_hold != '0) begin
                            r_hold <= r_hold - HOLD_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (i_cmd.fold) begin
                if (is_spk) begin
                    if (r_mean > SUM_W'(r_spk_level)) begin
                        r_hold <= r_hold_ms;
                    end
                end else if (o_st.loud) begin
                    if (r_active) begin
                        r_tot_w <= r_tot_w + TOT_W'(r_mean);
                    end else begin
                        r_tot_wo <= r_tot_wo + TOT_W'(r_mean);
                    end
                end
            end

            if (i_cmd.avg_take) begin
                if (r_active) begin
                    r_avg_w <= new_avg;
                    r_tot_w <= restart ? TOT_W'(new_avg) : r_tot_w;
                    r_cnt_w <= restart ? '0 : cnt_next[CNT_W-1:0];
                end else begin
                    r_avg_wo <= new_avg;
                    r_tot_wo <= restart ? TOT_W'(new_avg) : r_tot_wo;
                    r_cnt_wo <= restart ? '0 : cnt_next[CNT_W-1:0];
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type   <= t_req_type'(i_req_type);
            r_sample <= i_sample;
            r_end    <= i_frame_end;
        end
        if (i_cmd.acc) begin
            r_active    <= r_hold != '0;
            r_frame_sum <= n_sum;
        end
        if (i_cmd.mean_take) begin
            r_mean <= mean_calc;
        end
        if (i_cmd.emit) begin
            r_suppress   <= n_suppress;
            r_spk_active <= r_active;
            r_out_w      <= r_avg_w;
            r_out_wo     <= r_avg_wo;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_suppress       = r_suppress;
    assign o_speaker_active = r_spk_active;
    assign o_level_with     = r_out_w;
    assign o_level_without  = r_out_wo;

    `CHK_NEXT(a_emit_valid, i_cmd.emit, r_out_valid, "Result register not loaded after emit.")

endmodule

// ===== rtl/core/frame_echo_suppressor.sv =====
// Top level of the frame echo suppressor: joins controller and datapath to the
// request, result and configuration channels. Depends on fes_pkg, fes_if, fes_ctrl, fes_dp.
//
//   Channel   Direction  Carries
//   i_req     in         req_type, sample, frame_end
//   o_res     out        suppress, speaker_active, level_with_speaker, level_without_speaker
//   i_cfg     in         index, data (always ready)
//
// A tick or a sample that does not end a frame passes the idle and accumulate states, a speaker
// frame end also mean and fold, and a microphone frame end also decide; the frame mean is a
// product with the reciprocal of the frame length. A loud microphone frame end also runs the
// one-bit-per-cycle 32-step divider for the running average. Reset is synchronous and needs
// no clearing pass. A new request is taken while a result still waits in the output register;
// only a following microphone frame end waits for that register to drain.

module frame_echo_suppressor
    import fes_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fes_req_if.sink    i_req,
    fes_res_if.source  o_res,
    fes_cfg_if.sink    i_cfg
);

    t_fes_cmd    cmd;
    t_fes_status st;
    logic        in_ready;

    assign i_req.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    fes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_st       (st),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    fes_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_st             (st),
        .i_req_type       (i_req.req_type),
        .i_sample         (i_req.sample),
        .i_frame_end      (i_req.frame_end),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_res.ready),
        .o_out_valid      (o_res.valid),
        .o_suppress       (o_res.suppress),
        .o_speaker_active (o_res.speaker_active),
        .o_level_with     (o_res.level_with_speaker),
        .o_level_without  (o_res.level_without_speaker)
    );

endmodule
